// File: rtl/pisp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pisp_pkg
// Types, codes and sizes shared by the panel init-sequence parser.
// ---------------------------------------------------------------------------
package pisp_pkg;

  localparam int unsigned MAX_SEQ_BYTES = 4096;
  localparam int unsigned POS_W         = $clog2(MAX_SEQ_BYTES + 1);
  localparam int unsigned OFFSET_W      = 12;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  localparam logic [7:0] OP_CMD   = 8'h01;
  localparam logic [7:0] OP_DELAY = 8'h02;

  // byte classes
  localparam logic [2:0] KIND_CMD_OPCODE  = 3'd0;
  localparam logic [2:0] KIND_CMD_COUNT   = 3'd1;
  localparam logic [2:0] KIND_PARAM_COUNT = 3'd2;
  localparam logic [2:0] KIND_CMD_BYTE    = 3'd3;
  localparam logic [2:0] KIND_PARAM_BYTE  = 3'd4;
  localparam logic [2:0] KIND_DELAY_OP    = 3'd5;
  localparam logic [2:0] KIND_DELAY_MS    = 3'd6;
  localparam logic [2:0] KIND_IGNORED     = 3'd7;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_TRUNC_HEADER = 3'd1;
  localparam logic [2:0] ERR_NO_CMD_BYTES = 3'd2;
  localparam logic [2:0] ERR_PAST_END     = 3'd3;
  localparam logic [2:0] ERR_TRUNC_DELAY  = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN_OP   = 3'd5;
  localparam logic [2:0] ERR_TOO_LONG     = 3'd6;

  typedef enum logic [2:0] {
    PH_OPCODE      = 3'd0,
    PH_CMD_COUNT   = 3'd1,
    PH_PARAM_COUNT = 3'd2,
    PH_CMD_BYTES   = 3'd3,
    PH_PARAM_BYTES = 3'd4,
    PH_DELAY_VALUE = 3'd5,
    PH_ERROR       = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] seq_byte;
    logic       last_byte;
  } seq_item_t;

  typedef struct packed {
    logic [2:0]          byte_kind;
    logic [7:0]          byte_value;
    logic [2:0]          error_code;
    logic [OFFSET_W-1:0] error_offset;
    logic                sequence_end;
  } result_item_t;

  // clamp a byte position to the reported offset range
  function automatic logic [OFFSET_W-1:0] sat_offset(input logic [POS_W-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return (w > 32'(OFFSET_MAX)) ? OFFSET_MAX : w[OFFSET_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/panel_init_sequence_parser.sv
`default_nettype none
// ---------------------------------------------------------------------------
// panel_init_sequence_parser
// Labels each byte of a panel init sequence and checks the sequence.
// ---------------------------------------------------------------------------
// Input channel seq_*: one sequence byte per beat, last_byte on the final one.
// Output channel res_*: exactly one result beat per input beat, in order,
// with the byte class, the byte itself, the latched error and its offset.
// A byte taken into the input holding register is labelled into the result
// register when the parse stage advances. Throughput: one byte per cycle when
// the output is not stalled; the parse state update is combinational logic
// between the input holding register and the result register.
// A stalled result holds its beat; the input register can still take one more
// byte behind it, after which seq_stall rises until the result is taken.
// Reset clears both registers' valid flags and puts the parser in its opcode
// phase with no error and position zero. The final byte of a sequence does
// the same to the parser state once it has been labelled.
// ---------------------------------------------------------------------------
module panel_init_sequence_parser (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   seq_valid,
  output logic                        seq_stall,
  input  wire pisp_pkg::seq_item_t    seq_data,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output pisp_pkg::result_item_t      res_data
);
  import pisp_pkg::*;

  logic         advance;
  logic         held_valid;
  seq_item_t    held_data;
  result_item_t result;

  pisp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .seq_valid  (seq_valid),
    .seq_stall  (seq_stall),
    .seq_data   (seq_data),
    .advance    (advance),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  pisp_parse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_data),
    .result  (result)
  );

  pisp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .result     (result),
    .advance    (advance),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

endmodule
`default_nettype wire

// File: rtl/pisp_in_reg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pisp_in_reg
// Input holding register; releases its beat when the parse stage advances.
// ---------------------------------------------------------------------------
module pisp_in_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                seq_valid,
  output logic                     seq_stall,
  input  wire pisp_pkg::seq_item_t seq_data,
  input  wire logic                advance,
  output logic                     held_valid,
  output pisp_pkg::seq_item_t      held_data
);
  import pisp_pkg::*;

  logic take;

  assign seq_stall = held_valid && !advance;
  assign take      = seq_valid && !seq_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_data <= seq_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pisp_parse_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pisp_parse_core
// Parser state and the per-byte classification and error checks.
// ---------------------------------------------------------------------------
module pisp_parse_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire pisp_pkg::seq_item_t item,
  output pisp_pkg::result_item_t   result
);
  import pisp_pkg::*;

  phase_t              phase, phase_next;
  logic [7:0]          cmd_left, cmd_left_next;
  logic [7:0]          param_left, param_left_next;
  logic [POS_W-1:0]    position, position_next;
  logic [OFFSET_W-1:0] elem_start, elem_start_next;
  logic [2:0]          latched_err, latched_err_next;

  logic [2:0] kind;
  logic [7:0] cmd_dec;
  logic [7:0] param_dec;
  logic       last;
  logic [7:0] b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_OPCODE;
      cmd_left    <= '0;
      param_left  <= '0;
      position    <= '0;
      elem_start  <= '0;
      latched_err <= ERR_NONE;
    end else if (advance) begin
      phase       <= phase_next;
      cmd_left    <= cmd_left_next;
      param_left  <= param_left_next;
      position    <= position_next;
      elem_start  <= elem_start_next;
      latched_err <= latched_err_next;
    end
  end

  always_comb begin
    b                = item.seq_byte;
    last             = item.last_byte;
    cmd_dec          = cmd_left - 8'd1;
    param_dec        = param_left - 8'd1;
    kind             = KIND_IGNORED;
    phase_next       = phase;
    cmd_left_next    = cmd_left;
    param_left_next  = param_left;
    elem_start_next  = elem_start;
    latched_err_next = latched_err;
    position_next    = (position == POS_W'(MAX_SEQ_BYTES)) ? position
                                                           : position + 1'b1;

    if (phase != PH_ERROR && position == POS_W'(MAX_SEQ_BYTES)) begin
      latched_err_next = ERR_TOO_LONG;
      elem_start_next  = (phase == PH_OPCODE) ? sat_offset(position) : elem_start;
      phase_next       = PH_ERROR;
    end else begin
      unique case (phase)
        PH_OPCODE: begin
          elem_start_next = sat_offset(position);
          if (b == OP_CMD) begin
            if (last) begin
              latched_err_next = ERR_TRUNC_HEADER;
              phase_next       = PH_ERROR;
            end else begin
              kind       = KIND_CMD_OPCODE;
              phase_next = PH_CMD_COUNT;
            end
          end else if (b == OP_DELAY) begin
            if (last) begin
              latched_err_next = ERR_TRUNC_DELAY;
              phase_next       = PH_ERROR;
            end else begin
              kind       = KIND_DELAY_OP;
              phase_next = PH_DELAY_VALUE;
            end
          end else begin
            latched_err_next = ERR_UNKNOWN_OP;
            phase_next       = PH_ERROR;
          end
        end
        PH_CMD_COUNT: begin
          if (last) begin
            latched_err_next = ERR_TRUNC_HEADER;
            phase_next       = PH_ERROR;
          end else if (b == 8'd0) begin
            latched_err_next = ERR_NO_CMD_BYTES;
            phase_next       = PH_ERROR;
          end else begin
            kind          = KIND_CMD_COUNT;
            cmd_left_next = b;
            phase_next    = PH_PARAM_COUNT;
          end
        end
        PH_PARAM_COUNT: begin
          if (last) begin
            latched_err_next = ERR_PAST_END;
            phase_next       = PH_ERROR;
          end else begin
            kind            = KIND_PARAM_COUNT;
            param_left_next = b;
            phase_next      = PH_CMD_BYTES;
          end
        end
        PH_CMD_BYTES: begin
          cmd_left_next = cmd_dec;
          if (last && (cmd_dec != 8'd0 || param_left != 8'd0)) begin
            latched_err_next = ERR_PAST_END;
            phase_next       = PH_ERROR;
          end else begin
            kind = KIND_CMD_BYTE;
            if (cmd_dec == 8'd0) begin
              phase_next = (param_left == 8'd0) ? PH_OPCODE : PH_PARAM_BYTES;
            end
          end
        end
        PH_PARAM_BYTES: begin
          param_left_next = param_dec;
          if (last && param_dec != 8'd0) begin
            latched_err_next = ERR_PAST_END;
            phase_next       = PH_ERROR;
          end else begin
            kind = KIND_PARAM_BYTE;
            if (param_dec == 8'd0) begin
              phase_next = PH_OPCODE;
            end
          end
        end
        PH_DELAY_VALUE: begin
          kind       = KIND_DELAY_MS;
          phase_next = PH_OPCODE;
        end
        default: begin
          phase_next = PH_ERROR;
        end
      endcase
    end

    result.byte_kind    = kind;
    result.byte_value   = b;
    result.error_code   = latched_err_next;
    result.error_offset = (latched_err_next == ERR_NONE) ? '0 : elem_start_next;
    result.sequence_end = last;

    // final byte returns everything to its reset value
    if (last) begin
      phase_next       = PH_OPCODE;
      cmd_left_next    = '0;
      param_left_next  = '0;
      position_next    = '0;
      elem_start_next  = '0;
      latched_err_next = ERR_NONE;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pisp_out_reg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pisp_out_reg
// Result register; loads when the parse stage advances, holds while stalled.
// ---------------------------------------------------------------------------
module pisp_out_reg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   held_valid,
  input  wire pisp_pkg::result_item_t result,
  output logic                        advance,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output pisp_pkg::result_item_t      res_data
);
  import pisp_pkg::*;

  assign advance = held_valid && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= result;
    end
  end

endmodule
`default_nettype wire
